// ===== design/rgbfx_pkg.sv =====
`timescale 1ns / 1ps

package rgbfx_pkg;

  localparam int LED_COUNT     = 4;
  localparam int TOP_LEVEL     = 9;
  localparam int WHITE_LEVEL   = 7;
  localparam int RAINBOW_LEVEL = 9;

  localparam int LEVEL_W = 4;
  localparam int HUE_W   = 10;
  localparam int COLOR_W = 8;
  localparam int IDX_W   = 6;

  // Hue distance between neighbouring LEDs in rainbow mode.
  localparam int HUE_STEP  = 768 / LED_COUNT;
  localparam int HUE_CYCLE = 768;

  localparam logic [COLOR_W-1:0] SAT_FULL    = 8'd255;
  localparam logic [COLOR_W-1:0] BRI_DEFAULT = 8'd16;

  localparam int IN_DATA_W  = 24;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 32;

  typedef enum logic [2:0] {
    REQ_TICK     = 3'd0,
    REQ_TOGGLE   = 3'd1,
    REQ_ON       = 3'd2,
    REQ_OFF      = 3'd3,
    REQ_INCREASE = 3'd4,
    REQ_DECREASE = 3'd5,
    REQ_STEP     = 3'd6,
    REQ_SET_BRI  = 3'd7
  } req_t;

  typedef struct packed {
    logic accept;   // input transaction taken: update the effect state
    logic mul1;     // first multiply stage for the current LED
    logic mul2;     // second multiply stage for the current LED
    logic load;     // load the output register and move to the next LED
  } dp_cmd_t;

  typedef struct packed {
    logic refresh;  // the offered event produces a refresh run
    logic last;     // current LED is the final one of the run
  } dp_status_t;

endpackage

// ===== design/rgb_led_effect_controller.sv =====
`timescale 1ns / 1ps

// RGB LED effect controller.
// Input channel s_*: one user event per transaction (tick, toggle, on, off, increase,
// decrease, step, set brightness) with a snapshot of the backlight state. An event is
// taken only while the block is idle; an event that produces no colours leaves it idle.
// Output channel m_*: one colour per LED, LED 0 first, m_tlast set on the last LED.
// A refresh run produces LED_COUNT transactions. Each LED passes through two multiply
// stages and the output register in turn; the next LED starts only once the current
// colour is loaded, and the block returns to idle when the last colour is loaded.
// If m_tready is held low the colour stays in the output register and the run pauses;
// the next event may be taken while the final colour still waits.
// Reset (rst, synchronous) sets level 0, lights off, saturation 255, brightness 16,
// no fading and clears the output valid flag.

module rgb_led_effect_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // brightness_value[7:0], backlight_enable[8], backlight_level[12:9],
  // bl_brightness[20:13], zero pad [23:21]
  input  logic [rgbfx_pkg::IN_DATA_W-1:0]       s_tdata,
  // req_type[2:0]
  input  logic [rgbfx_pkg::IN_USER_W-1:0]       s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // led_index[5:0], red[13:6], green[21:14], blue[29:22], zero pad [31:30]
  output logic [rgbfx_pkg::OUT_DATA_W-1:0]      m_tdata,
  output logic                                  m_tlast
);

  rgbfx_pkg::dp_cmd_t    cmd;
  rgbfx_pkg::dp_status_t status;

  rgbfx_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  rgbfx_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

endmodule

// ===== design/rgbfx_ctrl.sv =====
`timescale 1ns / 1ps

module rgbfx_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  input  rgbfx_pkg::dp_status_t status,
  output rgbfx_pkg::dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL1 = 4'b0010,
    ST_MUL2 = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;
  logic   m_tvalid_next;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          if (status.refresh) begin
            state_next = ST_MUL1;
          end
        end
      end
      ST_MUL1: begin
        cmd.mul1   = 1'b1;
        state_next = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // The result register must be empty, or emptied this cycle, before it is reloaded.
        if (out_free) begin
          cmd.load   = 1'b1;
          state_next = status.last ? ST_IDLE : ST_MUL1;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_tvalid_next = m_tvalid;
    if (cmd.load) begin
      m_tvalid_next = 1'b1;
    end else if (m_tready) begin
      m_tvalid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

endmodule

// ===== design/rgbfx_datapath.sv =====
`timescale 1ns / 1ps

module rgbfx_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic [rgbfx_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic [rgbfx_pkg::IN_USER_W-1:0]      s_tuser,
  input  rgbfx_pkg::dp_cmd_t                   cmd,
  output rgbfx_pkg::dp_status_t                status,
  output logic [rgbfx_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                 m_tlast
);

  localparam logic [rgbfx_pkg::LEVEL_W-1:0] LVL_TOP =
    rgbfx_pkg::LEVEL_W'(rgbfx_pkg::TOP_LEVEL);
  localparam logic [rgbfx_pkg::LEVEL_W-1:0] LVL_WHITE =
    rgbfx_pkg::LEVEL_W'(rgbfx_pkg::WHITE_LEVEL);
  localparam logic [rgbfx_pkg::LEVEL_W-1:0] LVL_RAINBOW =
    rgbfx_pkg::LEVEL_W'(rgbfx_pkg::RAINBOW_LEVEL);
  localparam logic [rgbfx_pkg::HUE_W-1:0] HUE_INC =
    rgbfx_pkg::HUE_W'(rgbfx_pkg::HUE_STEP);
  localparam logic [rgbfx_pkg::HUE_W:0] HUE_WRAP =
    (rgbfx_pkg::HUE_W + 1)'(rgbfx_pkg::HUE_CYCLE);
  localparam logic [rgbfx_pkg::IDX_W-1:0] IDX_LAST =
    rgbfx_pkg::IDX_W'(rgbfx_pkg::LED_COUNT - 1);

  // Input fields
  logic [7:0] bri_val;
  logic       bl_en;
  logic [3:0] bl_lvl;
  logic [7:0] bl_bri;
  logic [2:0] req;

  // Effect state
  logic [3:0] current_level,    current_level_next;
  logic       lights_enabled,   lights_enabled_next;
  logic [9:0] base_hue,         base_hue_next;
  logic [7:0] color_saturation, color_saturation_next;
  logic [7:0] color_brightness, color_brightness_next;
  logic       fade_active,      fade_active_next;
  logic       rainbow_active,   rainbow_active_next;
  logic [1:0] fade_phase,       fade_phase_next;
  logic [9:0] fade_hue,         fade_hue_next;

  logic       refresh;
  logic       do_apply;
  logic [3:0] apply_lvl;
  logic [1:0] phase_inc;
  logic [10:0] fade_hue_inc;
  logic       bri_from_bl;

  // Per-LED pipeline
  logic [5:0]  led_idx;
  logic [9:0]  hue_ofs;
  logic [10:0] led_hue;
  logic [1:0]  sector;
  logic [1:0]  sector_q;
  logic [1:0]  sector_qq;
  logic [15:0] prod_hs;
  logic [16:0] prod_sb;
  logic [15:0] prod_x;
  logic [7:0]  x_val;
  logic [7:0]  s_val;
  logic [7:0]  sum_xs;
  logic [7:0]  diff_bx;
  logic [7:0]  red_c, green_c, blue_c;

  // Output register
  logic [5:0] out_idx;
  logic [7:0] out_red, out_green, out_blue;
  logic       out_last;

  assign req     = s_tuser;
  assign bri_val = s_tdata[7:0];
  assign bl_en   = s_tdata[8];
  assign bl_lvl  = s_tdata[12:9];
  assign bl_bri  = s_tdata[20:13];

  assign bri_from_bl  = (bl_lvl >= 4'd1) && (bl_lvl <= 4'd3);
  assign phase_inc    = fade_phase + 2'd1;
  assign fade_hue_inc = {1'b0, fade_hue} + 11'd1;

  always_comb begin
    current_level_next    = current_level;
    lights_enabled_next   = lights_enabled;
    base_hue_next         = base_hue;
    color_saturation_next = color_saturation;
    color_brightness_next = color_brightness;
    fade_active_next      = fade_active;
    rainbow_active_next   = rainbow_active;
    fade_phase_next       = fade_phase;
    fade_hue_next         = fade_hue;
    refresh               = 1'b0;
    do_apply              = 1'b0;
    apply_lvl             = current_level;

    unique case (req)
      rgbfx_pkg::REQ_TICK: begin
        if (fade_active) begin
          if (phase_inc > 2'd1) begin
            fade_phase_next = 2'd0;
            base_hue_next   = fade_hue;
            fade_hue_next   = (fade_hue_inc >= HUE_WRAP) ? 10'd0 : fade_hue_inc[9:0];
            refresh         = 1'b1;
          end else begin
            fade_phase_next = phase_inc;
          end
        end
      end
      rgbfx_pkg::REQ_TOGGLE: begin
        do_apply            = 1'b1;
        lights_enabled_next = !lights_enabled;
        apply_lvl           = lights_enabled ? 4'd0 : current_level;
      end
      rgbfx_pkg::REQ_ON: begin
        do_apply            = 1'b1;
        lights_enabled_next = 1'b1;
      end
      rgbfx_pkg::REQ_OFF: begin
        do_apply            = 1'b1;
        lights_enabled_next = 1'b0;
        apply_lvl           = 4'd0;
      end
      rgbfx_pkg::REQ_INCREASE: begin
        do_apply = 1'b1;
        if (current_level < LVL_TOP) begin
          current_level_next  = current_level + 4'd1;
          lights_enabled_next = 1'b1;
          apply_lvl           = current_level + 4'd1;
        end
      end
      rgbfx_pkg::REQ_DECREASE: begin
        do_apply = 1'b1;
        if (current_level != 4'd0) begin
          current_level_next  = current_level - 4'd1;
          lights_enabled_next = (current_level != 4'd1);
          apply_lvl           = current_level - 4'd1;
        end
      end
      rgbfx_pkg::REQ_STEP: begin
        do_apply  = 1'b1;
        apply_lvl = current_level + 4'd1;
        if (apply_lvl > LVL_TOP) begin
          apply_lvl = 4'd0;
        end
        current_level_next  = apply_lvl;
        lights_enabled_next = (apply_lvl != 4'd0);
      end
      rgbfx_pkg::REQ_SET_BRI: begin
        if (lights_enabled) begin
          color_brightness_next = bri_val;
          refresh               = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (do_apply) begin
      // Level zero blanks; otherwise the backlight may lend its brightness.
      if (apply_lvl == 4'd0) begin
        color_brightness_next = 8'd0;
      end else if (!bl_en) begin
        color_brightness_next = rgbfx_pkg::BRI_DEFAULT;
      end else if (bri_from_bl) begin
        color_brightness_next = bl_bri;
      end

      if (apply_lvl <= LVL_WHITE) begin
        fade_active_next    = 1'b0;
        rainbow_active_next = 1'b0;
        refresh             = 1'b1;
        if (apply_lvl == LVL_WHITE) begin
          color_saturation_next = 8'd0;
        end else if (apply_lvl != 4'd0) begin
          base_hue_next         = {3'(apply_lvl - 4'd1), 7'd0};
          color_saturation_next = rgbfx_pkg::SAT_FULL;
        end
      end else begin
        color_saturation_next = rgbfx_pkg::SAT_FULL;
        fade_active_next      = 1'b1;
        rainbow_active_next   = (apply_lvl >= LVL_RAINBOW);
      end
    end
  end

  assign status.refresh = refresh;
  assign status.last    = (led_idx == IDX_LAST);

  always_ff @(posedge clk) begin
    if (rst) begin
      current_level    <= 4'd0;
      lights_enabled   <= 1'b0;
      base_hue         <= 10'd0;
      color_saturation <= rgbfx_pkg::SAT_FULL;
      color_brightness <= rgbfx_pkg::BRI_DEFAULT;
      fade_active      <= 1'b0;
      rainbow_active   <= 1'b0;
      fade_phase       <= 2'd0;
      fade_hue         <= 10'd0;
    end else if (cmd.accept) begin
      current_level    <= current_level_next;
      lights_enabled   <= lights_enabled_next;
      base_hue         <= base_hue_next;
      color_saturation <= color_saturation_next;
      color_brightness <= color_brightness_next;
      fade_active      <= fade_active_next;
      rainbow_active   <= rainbow_active_next;
      fade_phase       <= fade_phase_next;
      fade_hue         <= fade_hue_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      led_idx <= '0;
      hue_ofs <= '0;
    end else if (cmd.accept) begin
      led_idx <= '0;
      hue_ofs <= '0;
    end else if (cmd.load) begin
      led_idx <= led_idx + 6'd1;
      hue_ofs <= hue_ofs + HUE_INC;
    end
  end

  assign led_hue = {1'b0, base_hue} + (rainbow_active ? {1'b0, hue_ofs} : 11'd0);

  // Colour sector is (hue / 256) mod 3.
  always_comb begin
    case (led_hue[10:8]) inside
      3'd0, 3'd3, 3'd6: sector = 2'd0;
      3'd1, 3'd4, 3'd7: sector = 2'd1;
      default:          sector = 2'd2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul1) begin
      prod_hs  <= {8'd0, led_hue[7:0]} * {8'd0, color_saturation};
      prod_sb  <= {8'd0, (9'd256 - {1'b0, color_saturation})} * {9'd0, color_brightness};
      sector_q <= sector;
    end
    if (cmd.mul2) begin
      x_val     <= prod_x[15:8];
      s_val     <= prod_sb[15:8];
      sector_qq <= sector_q;
    end
  end

  assign prod_x  = {8'd0, prod_hs[15:8]} * {8'd0, color_brightness};
  assign sum_xs  = x_val + s_val;
  assign diff_bx = color_brightness - x_val;

  always_comb begin
    case (sector_qq)
      2'd0: begin
        red_c   = diff_bx;
        green_c = sum_xs;
        blue_c  = s_val;
      end
      2'd1: begin
        red_c   = s_val;
        green_c = diff_bx;
        blue_c  = sum_xs;
      end
      default: begin
        red_c   = sum_xs;
        green_c = s_val;
        blue_c  = diff_bx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_idx   <= led_idx;
      out_red   <= red_c;
      out_green <= green_c;
      out_blue  <= blue_c;
      out_last  <= (led_idx == IDX_LAST);
    end
  end

  assign m_tdata = {2'b00, out_blue, out_green, out_red, out_idx};
  assign m_tlast = out_last;

endmodule

// ===== tb/sv/tb_rgb_led_effect_controller.sv =====
`timescale 1ns / 1ps

module tb_rgb_led_effect_controller;

  typedef struct {
    rgbfx_pkg::req_t req;
    logic [7:0]      new_bri;
    logic            bl_on;
    logic [3:0]      bl_level;
    logic [7:0]      bl_bri;
  } user_event_t;

  typedef struct {
    logic [5:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } led_color_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             s_tvalid = 1'b0;
  logic                             s_tready;
  logic [rgbfx_pkg::IN_DATA_W-1:0]  s_tdata = '0;
  logic [rgbfx_pkg::IN_USER_W-1:0]  s_tuser = '0;
  logic                             m_tvalid;
  logic                             m_tready = 1'b0;
  logic [rgbfx_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                             m_tlast;

  rgb_led_effect_controller dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  user_event_t pending_events[$];
  led_color_t  expected_colors[$];
  user_event_t cur_event;
  int unsigned events_total;
  int unsigned events_taken;
  int unsigned colors_seen;
  int unsigned mismatches;
  int unsigned gap_left;
  int unsigned hold_left;
  bit          src_burst;
  bit          sink_burst;

  // Effect state as the block should hold it.
  logic [3:0]  eff_level;
  logic        eff_enabled;
  logic [9:0]  eff_hue;
  logic [7:0]  eff_sat;
  logic [7:0]  eff_bri;
  logic        eff_fading;
  logic        eff_rainbow;
  logic [1:0]  eff_phase;
  logic [9:0]  eff_fade_hue;

  task automatic note_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Occasionally flips into or out of a stretch with no idling at all.
  function automatic int unsigned draw_idle(inout bit burst);
    if ($urandom_range(0, 19) == 0)
      burst = !burst;
    return burst ? 0 : $urandom_range(0, 15);
  endfunction

  function automatic void reset_effect();
    eff_level    = '0;
    eff_enabled  = 1'b0;
    eff_hue      = '0;
    eff_sat      = rgbfx_pkg::SAT_FULL;
    eff_bri      = rgbfx_pkg::BRI_DEFAULT;
    eff_fading   = 1'b0;
    eff_rainbow  = 1'b0;
    eff_phase    = '0;
    eff_fade_hue = '0;
  endfunction

  // Constant-brightness conversion of one hue to a colour.
  function automatic led_color_t shade(input int unsigned hue, input logic [7:0] sat,
                                       input logic [7:0] bri);
    led_color_t  c;
    logic [7:0]  tab[5];
    int unsigned sector;
    int unsigned x;
    int unsigned s;
    sector = (hue >> 8) % 3;
    x = (((((hue & 255) * sat) >> 8) * bri) >> 8) & 255;
    s = (((256 - sat) * bri) >> 8) & 255;
    tab[0] = s[7:0];
    tab[3] = s[7:0];
    tab[1] = 8'(x + s);
    tab[4] = tab[1];
    tab[2] = 8'(bri - x);
    c.red   = tab[sector + 2];
    c.green = tab[sector + 1];
    c.blue  = tab[sector];
    c.idx   = '0;
    c.last  = 1'b0;
    return c;
  endfunction

  function automatic void queue_refresh_run();
    led_color_t  c;
    int unsigned hue;
    for (int i = 0; i < rgbfx_pkg::LED_COUNT; i++) begin
      hue = eff_hue;
      if (eff_rainbow)
        hue = eff_hue + rgbfx_pkg::HUE_STEP * i;
      c = shade(hue & 16'hFFFF, eff_sat, eff_bri);
      c.idx  = 6'(i);
      c.last = (i == rgbfx_pkg::LED_COUNT - 1);
      expected_colors.push_back(c);
    end
  endfunction

  function automatic void take_backlight_bri(input user_event_t ev);
    if (ev.bl_on) begin
      if (ev.bl_level >= 1 && ev.bl_level <= 3)
        eff_bri = ev.bl_bri;
    end else begin
      eff_bri = rgbfx_pkg::BRI_DEFAULT;
    end
  endfunction

  function automatic void select_level(input logic [3:0] level, input user_event_t ev);
    if (level == 0)
      eff_bri = '0;
    else
      take_backlight_bri(ev);
    if (level <= rgbfx_pkg::WHITE_LEVEL) begin
      eff_fading  = 1'b0;
      eff_rainbow = 1'b0;
      if (level != 0) begin
        if (level == rgbfx_pkg::WHITE_LEVEL) begin
          eff_sat = '0;
        end else begin
          eff_hue = 10'((level - 1) * 128);
          eff_sat = rgbfx_pkg::SAT_FULL;
        end
        take_backlight_bri(ev);
      end
      queue_refresh_run();
    end else begin
      // Fading levels only arm the effect; colours follow on ticks.
      eff_sat     = rgbfx_pkg::SAT_FULL;
      eff_fading  = 1'b1;
      eff_rainbow = (level >= rgbfx_pkg::RAINBOW_LEVEL);
    end
  endfunction

  function automatic void advance_effect(input user_event_t ev);
    case (ev.req)
      rgbfx_pkg::REQ_TICK: begin
        if (eff_fading) begin
          eff_phase = eff_phase + 2'd1;
          if (eff_phase > 1) begin
            eff_phase    = '0;
            eff_hue      = eff_fade_hue;
            eff_fade_hue = (eff_fade_hue + 1 >= rgbfx_pkg::HUE_CYCLE) ? '0 :
                           eff_fade_hue + 10'd1;
            queue_refresh_run();
          end
        end
      end
      rgbfx_pkg::REQ_TOGGLE: begin
        if (eff_enabled) begin
          eff_enabled = 1'b0;
          select_level('0, ev);
        end else begin
          eff_enabled = 1'b1;
          select_level(eff_level, ev);
        end
      end
      rgbfx_pkg::REQ_ON: begin
        eff_enabled = 1'b1;
        select_level(eff_level, ev);
      end
      rgbfx_pkg::REQ_OFF: begin
        eff_enabled = 1'b0;
        select_level('0, ev);
      end
      rgbfx_pkg::REQ_INCREASE: begin
        if (eff_level < rgbfx_pkg::TOP_LEVEL) begin
          eff_level   = eff_level + 4'd1;
          eff_enabled = 1'b1;
        end
        select_level(eff_level, ev);
      end
      rgbfx_pkg::REQ_DECREASE: begin
        if (eff_level > 0) begin
          eff_level   = eff_level - 4'd1;
          eff_enabled = (eff_level != 0);
        end
        select_level(eff_level, ev);
      end
      rgbfx_pkg::REQ_STEP: begin
        eff_level = eff_level + 4'd1;
        if (eff_level > rgbfx_pkg::TOP_LEVEL)
          eff_level = '0;
        eff_enabled = (eff_level != 0);
        select_level(eff_level, ev);
      end
      rgbfx_pkg::REQ_SET_BRI: begin
        if (eff_enabled) begin
          eff_bri = ev.new_bri;
          queue_refresh_run();
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void add_event(input rgbfx_pkg::req_t req, input logic [7:0] new_bri,
                                    input logic bl_on, input logic [3:0] bl_level,
                                    input logic [7:0] bl_bri);
    user_event_t ev;
    ev.req      = req;
    ev.new_bri  = new_bri;
    ev.bl_on    = bl_on;
    ev.bl_level = bl_level;
    ev.bl_bri   = bl_bri;
    pending_events.push_back(ev);
  endfunction

  // Brightness values lean towards the extremes now and then.
  function automatic logic [7:0] any_bri();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly a level that lends its brightness, sometimes anything at all.
  function automatic void add_random_backlit(input rgbfx_pkg::req_t req);
    logic [3:0] lvl;
    lvl = ($urandom_range(0, 9) < 6) ? 4'($urandom_range(1, 3)) : 4'($urandom_range(0, 15));
    add_event(req, any_bri(), 1'($urandom_range(0, 1)), lvl, any_bri());
  endfunction

  function automatic rgbfx_pkg::req_t pick_request();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 40) return rgbfx_pkg::REQ_TICK;
    if (r < 52) return rgbfx_pkg::REQ_INCREASE;
    if (r < 60) return rgbfx_pkg::REQ_DECREASE;
    if (r < 70) return rgbfx_pkg::REQ_STEP;
    if (r < 78) return rgbfx_pkg::REQ_TOGGLE;
    if (r < 84) return rgbfx_pkg::REQ_ON;
    if (r < 88) return rgbfx_pkg::REQ_OFF;
    return rgbfx_pkg::REQ_SET_BRI;
  endfunction

  task automatic offer_next();
    cur_event = pending_events.pop_front();
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, cur_event.bl_bri, cur_event.bl_level, cur_event.bl_on,
                 cur_event.new_bri};
    s_tuser  <= cur_event.req;
  endtask

  always @(posedge clk) begin : source
    int unsigned gap;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left <= 0;
    end else if (s_tvalid && s_tready) begin
      advance_effect(cur_event);
      events_taken++;
      gap = draw_idle(src_burst);
      if (gap == 0 && pending_events.size() != 0) begin
        offer_next();
      end else begin
        s_tvalid <= 1'b0;
        gap_left <= (gap == 0) ? 0 : gap - 1;
      end
    end else if (!s_tvalid) begin
      if (gap_left != 0)
        gap_left <= gap_left - 1;
      else if (pending_events.size() != 0)
        offer_next();
    end
  end

  always @(posedge clk) begin : sink
    led_color_t  got;
    led_color_t  want;
    int unsigned pause;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_left <= 0;
    end else if (m_tvalid && m_tready) begin
      got.idx   = m_tdata[5:0];
      got.red   = m_tdata[13:6];
      got.green = m_tdata[21:14];
      got.blue  = m_tdata[29:22];
      got.last  = m_tlast;
      colors_seen++;
      if (expected_colors.size() == 0) begin
        note_mismatch($sformatf("unexpected colour for LED %0d", got.idx));
      end else begin
        want = expected_colors.pop_front();
        if (got.idx != want.idx)
          note_mismatch($sformatf("led_index %0d, wanted %0d", got.idx, want.idx));
        if (got.red != want.red)
          note_mismatch($sformatf("LED %0d red %0d, wanted %0d", want.idx, got.red,
                                  want.red));
        if (got.green != want.green)
          note_mismatch($sformatf("LED %0d green %0d, wanted %0d", want.idx, got.green,
                                  want.green));
        if (got.blue != want.blue)
          note_mismatch($sformatf("LED %0d blue %0d, wanted %0d", want.idx, got.blue,
                                  want.blue));
        if (got.last != want.last)
          note_mismatch($sformatf("LED %0d last flag %0b, wanted %0b", want.idx, got.last,
                                  want.last));
      end
      pause = draw_idle(sink_burst);
      m_tready  <= (pause == 0);
      hold_left <= pause;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= (hold_left == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  initial begin
    reset_effect();

    // Directed opening: every request, the extremes and the corner cases.
    add_event(rgbfx_pkg::REQ_TICK, 8'h00, 1'b0, 4'd0, 8'h00);
    add_event(rgbfx_pkg::REQ_SET_BRI, 8'h5A, 1'b1, 4'd1, 8'hFF);
    add_event(rgbfx_pkg::REQ_DECREASE, 8'hFF, 1'b1, 4'd2, 8'hFF);
    add_event(rgbfx_pkg::REQ_ON, 8'h00, 1'b1, 4'd3, 8'hA5);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'h00, 1'b1, 4'd1, 8'hFF);
    add_event(rgbfx_pkg::REQ_SET_BRI, 8'hFF, 1'b0, 4'd15, 8'h00);
    add_event(rgbfx_pkg::REQ_SET_BRI, 8'h00, 1'b1, 4'd0, 8'hFF);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'h00, 1'b1, 4'd3, 8'h80);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'h00, 1'b1, 4'd0, 8'h11);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'h00, 1'b0, 4'd2, 8'hFF);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'hFF, 1'b1, 4'd15, 8'h00);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'h00, 1'b1, 4'd2, 8'hFF);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'h00, 1'b1, 4'd1, 8'hC3);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'h00, 1'b1, 4'd3, 8'h40);
    add_event(rgbfx_pkg::REQ_TICK, 8'hFF, 1'b1, 4'd15, 8'hFF);
    add_event(rgbfx_pkg::REQ_TICK, 8'h00, 1'b0, 4'd0, 8'h00);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'h00, 1'b1, 4'd2, 8'hFF);
    add_event(rgbfx_pkg::REQ_TICK, 8'h00, 1'b0, 4'd0, 8'h00);
    add_event(rgbfx_pkg::REQ_TICK, 8'h00, 1'b0, 4'd0, 8'h00);
    add_event(rgbfx_pkg::REQ_INCREASE, 8'h00, 1'b1, 4'd1, 8'hFE);
    add_event(rgbfx_pkg::REQ_TICK, 8'h00, 1'b0, 4'd0, 8'h00);
    add_event(rgbfx_pkg::REQ_STEP, 8'h00, 1'b1, 4'd1, 8'h7F);
    add_event(rgbfx_pkg::REQ_STEP, 8'h00, 1'b1, 4'd1, 8'h7F);
    add_event(rgbfx_pkg::REQ_TOGGLE, 8'h00, 1'b1, 4'd3, 8'h01);
    add_event(rgbfx_pkg::REQ_TOGGLE, 8'h00, 1'b1, 4'd3, 8'h01);
    add_event(rgbfx_pkg::REQ_OFF, 8'h00, 1'b0, 4'd0, 8'h00);

    for (int i = 0; i < 340; i++)
      add_random_backlit(pick_request());

    // Walk to the rainbow level and tick through a few fade steps.
    add_random_backlit(rgbfx_pkg::REQ_OFF);
    for (int i = 0; i < 10; i++)
      add_random_backlit(rgbfx_pkg::REQ_DECREASE);
    for (int i = 0; i < 9; i++)
      add_random_backlit(rgbfx_pkg::REQ_INCREASE);
    for (int i = 0; i < 20; i++)
      add_random_backlit(($urandom_range(0, 9) == 0) ? rgbfx_pkg::REQ_SET_BRI :
                                                       rgbfx_pkg::REQ_TICK);

    events_total = pending_events.size();

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (events_taken != events_total || expected_colors.size() != 0)
      @(posedge clk);
    repeat (3 * rgbfx_pkg::LED_COUNT + 16) @(posedge clk);

    $display("Run covered %0d user events and %0d LED colour transactions.", events_taken,
             colors_seen);
    $display("Fixed hues, white, fading and rainbow levels were all exercised.");
    if (mismatches == 0) begin
      $display("tb_rgb_led_effect_controller: clean");
    end else begin
      $display("tb_rgb_led_effect_controller: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d colours still outstanding.", expected_colors.size());
    $display("tb_rgb_led_effect_controller: errors");
    $finish;
  end

endmodule
